/* rtl/core/tensor_patch_address_generator_defines.svh */
// Assertion macros shared by the address generator RTL.
`ifndef TENSOR_PATCH_ADDRESS_GENERATOR_DEFINES_SVH
`define TENSOR_PATCH_ADDRESS_GENERATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define TPAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define TPAG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* rtl/core/tpag_pkg.sv */
// Shared types, constants and helpers of the tensor patch address generator.
`timescale 1ns / 1ps
package tpag_pkg;

  localparam int IDX_W      = 40;  // element index width
  localparam int OUT_W      = 40;  // output offset width
  localparam int LANE_W     = 16;  // packed coordinate lane width
  localparam int LANE_COUNT = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_OFFSET_BITS = 40;
  localparam int DEF_COORD_BITS  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_RANK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_RANK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_END     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_EXT   = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RANK = 2'd1,
    STATUS_BAD_VIEW = 2'd2
  } status_e;

  // control that travels with each item down the chain
  typedef struct packed {
    logic    valid;
    status_e status;
  } tpag_ctl_t;

  // one 16-bit lane of a packed word; lanes past the fourth read as zero
  function automatic logic [LANE_W-1:0] get_lane(logic [CFG_DATA_W-1:0] word, int d);
    logic [LANE_W-1:0] res;
    res = '0;
    if (d < LANE_COUNT) begin
      res = word[d*LANE_W +: LANE_W];
    end
    return res;
  endfunction

endpackage

/* rtl/core/tpag_div_cell.sv */
// One restoring division step: shifts one index bit into the remainder.
`timescale 1ns / 1ps
module tpag_div_cell #(
  parameter int OFFSET_BITS = tpag_pkg::DEF_OFFSET_BITS,
  parameter int COORD_BITS  = tpag_pkg::DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  tpag_pkg::tpag_ctl_t          ctl_i,
  input  logic [tpag_pkg::IDX_W-1:0]   q_i,
  input  logic [COORD_BITS-1:0]        rem_i,
  input  logic [OFFSET_BITS-1:0]       toff_i,
  input  logic [OFFSET_BITS-1:0]       poff_i,
  input  logic [COORD_BITS-1:0]        span_i,
  output tpag_pkg::tpag_ctl_t          ctl_o,
  output logic [tpag_pkg::IDX_W-1:0]   q_o,
  output logic [COORD_BITS-1:0]        rem_o,
  output logic [OFFSET_BITS-1:0]       toff_o,
  output logic [OFFSET_BITS-1:0]       poff_o
);
  import tpag_pkg::*;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic [COORD_BITS-1:0] rem_d;
  logic [IDX_W-1:0]      q_d;
  tpag_ctl_t             ctl_q;
  logic [IDX_W-1:0]      q_q;
  logic [COORD_BITS-1:0] rem_q;
  logic [OFFSET_BITS-1:0] toff_q, poff_q;

  // trial subtract of the span from the shifted remainder
  always_comb begin
    trial = {rem_i, q_i[IDX_W-1]};
    diff  = trial - {1'b0, span_i};
    ge    = (trial >= {1'b0, span_i});
    rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    q_d   = {q_i[IDX_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, status: STATUS_OK};
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= q_d;
      rem_q  <= rem_d;
      toff_q <= toff_i;
      poff_q <= poff_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign q_o    = q_q;
  assign rem_o  = rem_q;
  assign toff_o = toff_q;
  assign poff_o = poff_q;

endmodule

/* rtl/core/tpag_acc_cell.sv */
// Per-dimension accumulate: adds the coordinate's share to both offsets when the dimension is active.
`timescale 1ns / 1ps
module tpag_acc_cell #(
  parameter int OFFSET_BITS = tpag_pkg::DEF_OFFSET_BITS,
  parameter int COORD_BITS  = tpag_pkg::DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  tpag_pkg::tpag_ctl_t          ctl_i,
  input  logic [tpag_pkg::IDX_W-1:0]   q_i,
  input  logic [COORD_BITS-1:0]        rem_i,
  input  logic [OFFSET_BITS-1:0]       toff_i,
  input  logic [OFFSET_BITS-1:0]       poff_i,
  input  logic [COORD_BITS-1:0]        start_i,
  input  logic [OFFSET_BITS-1:0]       tstride_i,
  input  logic [OFFSET_BITS-1:0]       pstride_i,
  input  logic                         active_i,
  output tpag_pkg::tpag_ctl_t          ctl_o,
  output logic [tpag_pkg::IDX_W-1:0]   q_o,
  output logic [COORD_BITS-1:0]        rem_o,
  output logic [OFFSET_BITS-1:0]       toff_o,
  output logic [OFFSET_BITS-1:0]       poff_o
);
  import tpag_pkg::*;

  localparam int TPROD_W = OFFSET_BITS + COORD_BITS + 1;
  localparam int PPROD_W = OFFSET_BITS + COORD_BITS;

  logic [COORD_BITS:0]    tcoord;
  logic [TPROD_W-1:0]     tprod;
  logic [PPROD_W-1:0]     pprod;
  logic [OFFSET_BITS-1:0] toff_d, poff_d;
  tpag_ctl_t              ctl_q;
  logic [IDX_W-1:0]       q_q;
  logic [OFFSET_BITS-1:0] toff_q, poff_q;

  // coordinate in the tensor is start plus coordinate in the view
  always_comb begin
    tcoord = {1'b0, rem_i} + {1'b0, start_i};
    tprod  = TPROD_W'(tstride_i) * TPROD_W'(tcoord);
    pprod  = PPROD_W'(pstride_i) * PPROD_W'(rem_i);
    toff_d = active_i ? toff_i + tprod[OFFSET_BITS-1:0] : toff_i;
    poff_d = active_i ? poff_i + pprod[OFFSET_BITS-1:0] : poff_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, status: STATUS_OK};
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= q_i;
      toff_q <= toff_d;
      poff_q <= poff_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign q_o    = q_q;
  assign rem_o  = '0;  // next dimension starts a fresh remainder
  assign toff_o = toff_q;
  assign poff_o = poff_q;

endmodule

/* rtl/core/tensor_patch_address_generator.sv */
// Top level: config registers, stride chains and the division/accumulate cell row.
// Throughput: one item per cycle while the output is not stalled; each dimension
// is 40 one-bit divide cells and one multiply-accumulate cell; the whole row stalls as one.
// Reset: rank 1, element size 1, view 0..1 and tensor extents 1 in all lanes; no items held.
// Strides settle through one register per dimension after a configuration write.
`timescale 1ns / 1ps
`include "tensor_patch_address_generator_defines.svh"
module tensor_patch_address_generator #(
  parameter int MAX_DIMS    = tpag_pkg::DEF_MAX_DIMS,
  parameter int OFFSET_BITS = tpag_pkg::DEF_OFFSET_BITS,
  parameter int COORD_BITS  = tpag_pkg::DEF_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpag_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,   // [39:0] element_index
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [39:0] tensor_offset, [79:40] patch_offset, [81:80] status, [87:82] zero
  output logic [87:0]                       m_axis_tdata
);
  import tpag_pkg::*;

  localparam int CELLS_PER_DIM = IDX_W + 1;
  localparam int NSTG          = MAX_DIMS * CELLS_PER_DIM;
  localparam int MUL_W         = OFFSET_BITS + COORD_BITS;

  // configuration registers
  logic [2:0]            patch_rank_q, tensor_rank_q;
  logic [3:0]            elem_bytes_q;
  logic [CFG_DATA_W-1:0] vstart_q, vend_q, text_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_rank_q  <= 3'd1;
      tensor_rank_q <= 3'd1;
      elem_bytes_q  <= 4'd1;
      vstart_q      <= '0;
      vend_q        <= 64'h0001_0001_0001_0001;
      text_q        <= 64'h0001_0001_0001_0001;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATCH_RANK:  patch_rank_q  <= cfg_wdata_i[2:0];
        REG_TENSOR_RANK: tensor_rank_q <= cfg_wdata_i[2:0];
        REG_ELEM_BYTES:  elem_bytes_q  <= cfg_wdata_i[3:0];
        REG_VIEW_START:  vstart_q      <= cfg_wdata_i;
        REG_VIEW_END:    vend_q        <= cfg_wdata_i;
        REG_TENSOR_EXT:  text_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-dimension view bounds
  logic [COORD_BITS-1:0]  vs [MAX_DIMS];
  logic [COORD_BITS-1:0]  ve [MAX_DIMS];
  logic [COORD_BITS-1:0]  tx [MAX_DIMS];
  logic [COORD_BITS-1:0]  span [MAX_DIMS];
  logic [MAX_DIMS-1:0]    active;
  logic [MAX_DIMS-1:0]    dim_bad;
  logic [OFFSET_BITS-1:0] tstr_q [MAX_DIMS];
  logic [OFFSET_BITS-1:0] pstr_q [MAX_DIMS];

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic [LANE_W-1:0] ls, le, lx;
    assign ls         = get_lane(vstart_q, d);
    assign le         = get_lane(vend_q, d);
    assign lx         = get_lane(text_q, d);
    assign vs[d]      = ls[COORD_BITS-1:0];
    assign ve[d]      = le[COORD_BITS-1:0];
    assign tx[d]      = lx[COORD_BITS-1:0];
    assign span[d]    = ve[d] - vs[d];
    assign active[d]  = (int'(patch_rank_q) > d);
    assign dim_bad[d] = active[d] && ((ve[d] <= vs[d]) || (ve[d] > tx[d]));

    // stride chain, a tensor and a patch multiply per dimension past the first
    if (d == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        tstr_q[d] <= OFFSET_BITS'(elem_bytes_q);
        pstr_q[d] <= OFFSET_BITS'(elem_bytes_q);
      end
    end else begin : g_next
      logic [MUL_W-1:0] tmul, pmul;
      assign tmul = MUL_W'(tstr_q[d-1]) * MUL_W'(tx[d-1]);
      assign pmul = MUL_W'(pstr_q[d-1]) * MUL_W'(span[d-1]);
      always_ff @(posedge clk_i) begin
        tstr_q[d] <= tmul[OFFSET_BITS-1:0];
        pstr_q[d] <= pmul[OFFSET_BITS-1:0];
      end
    end
  end

  // status of an item entering now; rank check wins
  logic    rank_bad;
  status_e in_status;
  always_comb begin
    rank_bad = (patch_rank_q == 3'd0) || (patch_rank_q > tensor_rank_q) ||
               (int'(patch_rank_q) > MAX_DIMS);
    if (rank_bad) begin
      in_status = STATUS_BAD_RANK;
    end else if (|dim_bad) begin
      in_status = STATUS_BAD_VIEW;
    end else begin
      in_status = STATUS_OK;
    end
  end

  // whole row advances unless a finished result is stalled
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tpag_ctl_t              ctl_s  [NSTG+1];
  logic [IDX_W-1:0]       q_s    [NSTG+1];
  logic [COORD_BITS-1:0]  rem_s  [NSTG+1];
  logic [OFFSET_BITS-1:0] toff_s [NSTG+1];
  logic [OFFSET_BITS-1:0] poff_s [NSTG+1];

  assign ctl_s[0]  = '{valid: s_axis_tvalid, status: in_status};
  assign q_s[0]    = s_axis_tdata[IDX_W-1:0];
  assign rem_s[0]  = '0;
  assign toff_s[0] = '0;
  assign poff_s[0] = '0;

  // cell row: per dimension, bit-serial divide then accumulate
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_row
    for (genvar b = 0; b < IDX_W; b++) begin : g_div
      localparam int K = d * CELLS_PER_DIM + b;
      tpag_div_cell #(.OFFSET_BITS(OFFSET_BITS), .COORD_BITS(COORD_BITS)) u_div (
        .clk_i, .rst_ni, .en_i(en),
        .ctl_i(ctl_s[K]), .q_i(q_s[K]), .rem_i(rem_s[K]),
        .toff_i(toff_s[K]), .poff_i(poff_s[K]), .span_i(span[d]),
        .ctl_o(ctl_s[K+1]), .q_o(q_s[K+1]), .rem_o(rem_s[K+1]),
        .toff_o(toff_s[K+1]), .poff_o(poff_s[K+1])
      );
    end
    localparam int KA = d * CELLS_PER_DIM + IDX_W;
    tpag_acc_cell #(.OFFSET_BITS(OFFSET_BITS), .COORD_BITS(COORD_BITS)) u_acc (
      .clk_i, .rst_ni, .en_i(en),
      .ctl_i(ctl_s[KA]), .q_i(q_s[KA]), .rem_i(rem_s[KA]),
      .toff_i(toff_s[KA]), .poff_i(poff_s[KA]),
      .start_i(vs[d]), .tstride_i(tstr_q[d]), .pstride_i(pstr_q[d]),
      .active_i(active[d]),
      .ctl_o(ctl_s[KA+1]), .q_o(q_s[KA+1]), .rem_o(rem_s[KA+1]),
      .toff_o(toff_s[KA+1]), .poff_o(poff_s[KA+1])
    );
  end

  // fit offsets to the output field width
  logic [OUT_W-1:0] toff_w, poff_w, toff_out, poff_out;
  if (OFFSET_BITS >= OUT_W) begin : g_trunc
    assign toff_w = toff_s[NSTG][OUT_W-1:0];
    assign poff_w = poff_s[NSTG][OUT_W-1:0];
  end else begin : g_ext
    assign toff_w = {{(OUT_W-OFFSET_BITS){1'b0}}, toff_s[NSTG]};
    assign poff_w = {{(OUT_W-OFFSET_BITS){1'b0}}, poff_s[NSTG]};
  end

  logic status_ok;
  assign status_ok = (ctl_s[NSTG].status == STATUS_OK);
  assign toff_out  = status_ok ? toff_w : '0;
  assign poff_out  = status_ok ? poff_w : '0;

  assign m_axis_tvalid = ctl_s[NSTG].valid;
  assign m_axis_tdata  = {6'b0, ctl_s[NSTG].status, poff_out, toff_out};

  `TPAG_ASSERT_IMP(a_err_zero, m_axis_tvalid && !status_ok, m_axis_tdata[79:0] == '0, "error offsets")
  `TPAG_ASSERT_NEVER(a_status_code, m_axis_tvalid && (m_axis_tdata[81:80] == 2'd3), "bad status")
  `TPAG_ASSERT_IMP(a_stall_block, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input in stall")
  `TPAG_ASSERT_IMP(a_acc_rem_clear, 1'b1, rem_s[CELLS_PER_DIM] == '0, "remainder not restarted")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the tensor patch address generator.
`timescale 1ns / 1ps
module tb;
  import tpag_pkg::*;

  localparam int LATENCY = 4 * 41;
  localparam int N_VECS  = 34;

  // row kinds of the directed table
  localparam logic CFG  = 1'b1;
  localparam logic ITEM = 1'b0;
  localparam logic FIX  = 1'b1;
  localparam logic PRED = 1'b0;

  // indexes past the last register, writes there are dropped
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] patch_off;
    logic [39:0] tensor_off;
  } addr_result_t;

  typedef struct {
    logic        is_cfg;     // register write instead of an item
    logic [2:0]  reg_idx;
    logic [63:0] value;      // register value, or element index in the low bits
    logic        fixed;      // expected result typed in below
    logic [1:0]  status;
    logic [39:0] tensor_off;
    logic [39:0] patch_off;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  // shadow copy of the configuration
  logic [2:0]  sh_patch_rank = 3'd1;
  logic [2:0]  sh_tensor_rank = 3'd1;
  logic [3:0]  sh_elem_bytes = 4'd1;
  logic [63:0] sh_start = '0;
  logic [63:0] sh_end = 64'h0001_0001_0001_0001;
  logic [63:0] sh_ext = 64'h0001_0001_0001_0001;

  addr_result_t pending_addrs[$];
  int errors = 0;
  int n_results = 0;
  int n_status[3] = '{0, 0, 0};
  bit long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  tensor_patch_address_generator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic logic [15:0] lane_of(logic [63:0] w, int d);
    return (d < 4) ? w[d*16 +: 16] : 16'd0;
  endfunction

  // expected offsets of one element index under the shadow configuration
  function automatic addr_result_t predict_addr(logic [39:0] index);
    addr_result_t r;
    logic [63:0] idx, toff, poff, ts, ps, s, span, coord;
    r = '0;
    if (sh_patch_rank == 0 || sh_patch_rank > sh_tensor_rank || sh_patch_rank > 4) begin
      r.status = STATUS_BAD_RANK;
      return r;
    end
    for (int d = 0; d < sh_patch_rank; d++)
      if (lane_of(sh_end, d) <= lane_of(sh_start, d) || lane_of(sh_end, d) > lane_of(sh_ext, d))
      begin
        r.status = STATUS_BAD_VIEW;
        return r;
      end
    idx = 64'(index);
    toff = 0;
    poff = 0;
    ts = 64'(sh_elem_bytes);
    ps = ts;
    for (int d = 0; d < sh_patch_rank; d++) begin
      s = 64'(lane_of(sh_start, d));
      span = 64'(lane_of(sh_end, d)) - s;
      coord = idx % span;
      toff += ts * (coord + s);
      poff += ps * coord;
      idx /= span;
      ts *= 64'(lane_of(sh_ext, d));
      ps *= span;
    end
    r.tensor_off = toff[39:0];
    r.patch_off = poff[39:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  // one register write, followed by idle on the write port
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PATCH_RANK:  sh_patch_rank = val[2:0];
      REG_TENSOR_RANK: sh_tensor_rank = val[2:0];
      REG_ELEM_BYTES:  sh_elem_bytes = val[3:0];
      REG_VIEW_START:  sh_start = val;
      REG_VIEW_END:    sh_end = val;
      REG_TENSOR_EXT:  sh_ext = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // drops valid, waits until idle, then lets strides settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // valid stays high after the accept; a gap in the next call or drain takes it down
  task automatic send_index(logic [39:0] index, addr_result_t exp_r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= index;
    pending_addrs.push_back(exp_r);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sets a full random but valid view of the given rank
  task automatic set_view(int rank, int max_span, logic [3:0] eb);
    logic [63:0] st, en, ex;
    int s, sp;
    st = '0;
    en = '0;
    ex = '0;
    for (int d = 0; d < 4; d++) begin
      s = $urandom_range(0, 20);
      sp = $urandom_range(1, max_span);
      st[d*16 +: 16] = 16'(s);
      en[d*16 +: 16] = 16'(s + sp);
      ex[d*16 +: 16] = 16'(s + sp + $urandom_range(0, 30));
    end
    write_reg(REG_TENSOR_RANK, 64'(rank + $urandom_range(0, 4 - rank)));
    write_reg(REG_PATCH_RANK, 64'(rank));
    write_reg(REG_ELEM_BYTES, 64'(eb));
    write_reg(REG_VIEW_START, st);
    write_reg(REG_VIEW_END, en);
    write_reg(REG_TENSOR_EXT, ex);
    repeat (8) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    addr_result_t act, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      act = addr_result_t'(m_axis_tdata[81:0]);
      if (pending_addrs.size() == 0) begin
        $error("result with no item outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_addrs.pop_front();
        n_results++;
        if (exp_r.status < 3) n_status[exp_r.status]++;
        if (act.tensor_off !== exp_r.tensor_off) begin
          $error("tensor_offset exp %h got %h", exp_r.tensor_off, act.tensor_off);
          errors++;
        end
        if (act.patch_off !== exp_r.patch_off) begin
          $error("patch_offset exp %h got %h", exp_r.patch_off, act.patch_off);
          errors++;
        end
        if (act.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, act.status);
          errors++;
        end
        if (m_axis_tdata[87:82] !== 6'd0) begin
          $error("pad bits exp 0 got %h", m_axis_tdata[87:82]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      m_axis_tready <= 1'b1;
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (w != 0) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (w - 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    vec_t vecs [N_VECS];
    addr_result_t e;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (8) @(posedge clk_i);

    vecs = '{
      // after reset: rank 1, span 1, every index maps to zero
      '{ITEM, '0, 64'd0, FIX, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'hFF_FFFF_FFFF, FIX, STATUS_OK, 40'd0, 40'd0},
      // bad ranks: zero, above tensor rank, above limit
      '{CFG, REG_PATCH_RANK, 64'd0, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd5, FIX, STATUS_BAD_RANK, 40'd0, 40'd0},
      '{CFG, REG_PATCH_RANK, 64'd2, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'hFF_FFFF_FFFF, FIX, STATUS_BAD_RANK, 40'd0, 40'd0},
      '{CFG, REG_TENSOR_RANK, 64'd7, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_PATCH_RANK, 64'd5, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd1, FIX, STATUS_BAD_RANK, 40'd0, 40'd0},
      // rank 2 with reset lanes is valid; then bad view cases
      '{CFG, REG_PATCH_RANK, 64'd2, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd3, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_VIEW_START, 64'h0000_0000_0001_0000, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd3, FIX, STATUS_BAD_VIEW, 40'd0, 40'd0},
      '{CFG, REG_VIEW_START, 64'd0, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_VIEW_END, 64'h0001_0001_0002_0001, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd3, FIX, STATUS_BAD_VIEW, 40'd0, 40'd0},
      // extreme geometry: full 16-bit lanes, 8-byte, 0-byte and 15-byte elements
      '{CFG, REG_TENSOR_RANK, 64'd4, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_PATCH_RANK, 64'd4, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_ELEM_BYTES, 64'd8, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_VIEW_START, 64'h0000_FFFE_0000_0001, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_VIEW_END, 64'hFFFF_FFFF_FFFF_FFFF, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_TENSOR_EXT, 64'hFFFF_FFFF_FFFF_FFFF, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd0, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd1, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'hFF_FFFF_FFFF, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'hAA_AAAA_AAAA, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'h55_5555_5555, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_ELEM_BYTES, 64'd0, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'h12_3456_789A, FIX, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_ELEM_BYTES, 64'd15, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd777, PRED, STATUS_OK, 40'd0, 40'd0},
      // writes past the last register leave the geometry alone
      '{CFG, REG_SPARE_A, 64'hDEAD, PRED, STATUS_OK, 40'd0, 40'd0},
      '{CFG, REG_SPARE_B, 64'hBEEF, PRED, STATUS_OK, 40'd0, 40'd0},
      '{ITEM, '0, 64'd778, PRED, STATUS_OK, 40'd0, 40'd0}
    };

    // directed table: register writes only while idle
    foreach (vecs[i]) begin
      if (vecs[i].is_cfg) begin
        drain();
        write_reg(vecs[i].reg_idx, vecs[i].value);
      end else begin
        if (vecs[i].fixed) begin
          e = '{status: vecs[i].status, patch_off: vecs[i].patch_off,
                tensor_off: vecs[i].tensor_off};
        end else begin
          e = predict_addr(vecs[i].value[39:0]);
        end
        send_index(vecs[i].value[39:0], e);
      end
    end

    // random phases: mostly valid views, some broken ones
    for (int ph = 0; ph < 35; ph++) begin
      int n_items;
      n_items = (ph == 10) ? 250 : 43;
      drain();
      set_view($urandom_range(1, 4), (ph % 5 == 0) ? 4000 : 12, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 6) == 0) write_reg(REG_PATCH_RANK, 64'($urandom_range(0, 7)));
      if ($urandom_range(0, 6) == 0) write_reg(REG_VIEW_END, {$urandom, $urandom});
      if (ph == 10) long_hold = 1'b1;
      repeat (8) @(posedge clk_i);
      for (int k = 0; k < n_items; k++) begin
        logic [39:0] x;
        x = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom})
                                         : 40'($urandom_range(0, 5000));
        if (ph == 10) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= x;
          pending_addrs.push_back(predict_addr(x));
          do @(posedge clk_i); while (!s_axis_tready);
        end else begin
          send_index(x, predict_addr(x));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d addresses: %0d in range, %0d bad rank, %0d bad view.",
             n_results, n_status[0], n_status[1], n_status[2]);
    $display("Covered reset geometry, rank and view errors, full lanes and a long output stall.");
    if (errors == 0 && pending_addrs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tpag_pkg.sv
rtl/core/tpag_div_cell.sv
rtl/core/tpag_acc_cell.sv
rtl/core/tensor_patch_address_generator.sv
dv/tb.sv
